// ===== hw/rtl/wssc_pkg.sv =====
// Shared types, constants and helpers for the windowed SRAM core.
// Used by the controller, the datapath, the bank memory and the checker.
`default_nettype none

package wssc_pkg;

   // Store geometry: eight byte lanes, each lane a bank of rows.
   localparam int STORE_LOG2   = 16;
   localparam int STORE_BYTES  = 1 << STORE_LOG2;
   localparam int MAX_TRANSFER = 8;
   localparam int LANES        = 8;
   localparam int LANE_LOG2    = 3;
   localparam int ROW_BITS     = STORE_LOG2 - LANE_LOG2;
   localparam int ROWS         = 1 << ROW_BITS;

   localparam int WINDOW_LOG2_MAX = 32;

   // Port widths.
   localparam int REQ_TDATA_W = 112;
   localparam int RSP_TDATA_W = 256;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_W-1:0] REG_REGION_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WINDOW_LOG2 = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CAPACITY_LOG2 = 2'd2;

   typedef enum logic [1:0] {
      KIND_READ        = 2'd0,
      KIND_WRITE       = 2'd1,
      KIND_DEBUG_READ  = 2'd2,
      KIND_DEBUG_WRITE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_SIZE_ERR   = 2'd1,
      ST_DECODE_ERR = 2'd2,
      ST_CAP_ERR    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_CHECK,
      S_DECIDE,
      S_ACCESS,
      S_FINISH
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic capture;
      logic check;
      logic decide;
      logic access;
      logic load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic out_free;
   } stat_type;

   // Saturating add of a small count to a 32-bit counter.
   function automatic logic [31:0] sat_add(input logic [31:0] count, input logic [3:0] n);
      logic [32:0] sum;
      sum = {1'b0, count} + 33'(n);
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/windowed_sram_with_strobes_and_counters_core.sv =====
// Windowed byte SRAM with byte strobes and saturating traffic counters.
// An accepted item passes the check, decide, bank access and result steps of
// the controller, which works on one item at a time; the result step waits
// only while the previous result is still unclaimed.
// Reset: synchronous; the store is then cleared one row of all eight banks per
// cycle, 8192 rows, during which no item is accepted (csr writes are taken).
`default_nettype none

module windowed_sram_with_strobes_and_counters_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // tdata: byte_address, transfer_size, write_data, strobe_mask, zero pad
   input  wire logic [wssc_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: req_type
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // tdata: read_data, read_total, write_total, bytes_read_total,
   // bytes_written_total, error_total, debug_written_total
   output logic      [wssc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // tuser: status
   output logic      [1:0]                       rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [wssc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wssc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wssc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   wssc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wssc_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/wssc_bank.sv =====
// One byte lane of the store: a single-port row memory with registered read.
// Depends on wssc_pkg for the row count.
`default_nettype none

module wssc_bank (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic                          re,
   input  wire logic [wssc_pkg::ROW_BITS-1:0] addr,
   input  wire logic [7:0]                    wdata,
   output logic      [7:0]                    rdata_ff
);
   import wssc_pkg::*;

   logic [7:0] mem [ROWS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wssc_datapath.sv =====
// Datapath: configuration registers, request registers, span checks,
// the eight lane banks, saturating counters and the result register.
// Depends on wssc_pkg and wssc_bank; driven by commands from wssc_ctrl.
`default_nettype none

module wssc_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire wssc_pkg::cmd_type                cmd,
   output wssc_pkg::stat_type                    stat,
   input  wire logic [wssc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [1:0]                       req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [wssc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic      [1:0]                       rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [wssc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [wssc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import wssc_pkg::*;

   // Configuration.
   logic [31:0] base_ff;
   logic [5:0]  wlog_cfg_ff;
   logic [4:0]  cap_cfg_ff;

   // Clearing sweep.
   logic [ROW_BITS-1:0] clear_row_ff;

   // Captured request.
   logic [1:0]  kind_ff;
   logic [31:0] addr_ff;
   logic [3:0]  size_ff;
   logic [63:0] wdata_ff;
   logic [7:0]  strobe_ff;

   // Check stage.
   logic [33:0] end_ff, end_in;
   logic [33:0] win_lim_ff, win_lim_in;
   logic [33:0] cap_lim_ff, cap_lim_in;
   logic [7:0]  lane_en_ff, lane_en_in;
   logic [3:0]  moved_ff, moved_in;
   logic        size_bad_ff, size_bad_in;

   // Decide stage.
   status_type            status_ff, status_in;
   logic [STORE_LOG2-1:0] offset_ff;

   // Counters.
   logic [31:0] read_cnt_ff, write_cnt_ff, rbytes_cnt_ff, wbytes_cnt_ff;
   logic [31:0] err_cnt_ff, dbg_cnt_ff;

   // Result register.
   logic                   rsp_valid_ff;
   status_type             rsp_status_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [5:0] wlog;
   logic [5:0] cap_log;
   logic       writing;
   logic       counted;
   logic       ok;

   logic [ROW_BITS-1:0] bank_addr  [LANES];
   logic                bank_we    [LANES];
   logic [7:0]          bank_wdata [LANES];
   logic [7:0]          bank_rdata [LANES];
   logic [63:0]         rdata;

   assign writing = kind_ff[0];
   assign counted = !kind_ff[1];
   assign ok      = (status_ff == ST_OK);

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff     <= '0;
         wlog_cfg_ff <= 6'd16;
         cap_cfg_ff  <= 5'd16;
      end else if (csr_we) begin
         case (csr_index)
            REG_REGION_BASE:   base_ff     <= csr_wdata;
            REG_WINDOW_LOG2:   wlog_cfg_ff <= csr_wdata[5:0];
            REG_CAPACITY_LOG2: cap_cfg_ff  <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // Clearing sweep, one row of every bank per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_row_ff <= '0;
      end else if (cmd.clear) begin
         clear_row_ff <= clear_row_ff + 1'b1;
      end
   end

   assign stat.clear_last = (clear_row_ff == ROW_BITS'(ROWS - 1));
   assign stat.out_free   = !rsp_valid_ff || rsp_tready;

   // Capture: tdata holds address, size, write data and strobes from bit 0 up.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff   <= req_tuser;
         addr_ff   <= req_tdata[31:0];
         size_ff   <= req_tdata[35:32];
         wdata_ff  <= req_tdata[99:36];
         strobe_ff <= req_tdata[107:100];
      end
   end

   // Window and capacity limits, span end, enabled lanes.
   always_comb begin
      wlog = (wlog_cfg_ff > 6'(WINDOW_LOG2_MAX)) ? 6'(WINDOW_LOG2_MAX) : wlog_cfg_ff;
      cap_log = {1'b0, cap_cfg_ff};
      if (cap_log > wlog) begin
         cap_log = wlog;
      end
      if (cap_log > 6'(STORE_LOG2)) begin
         cap_log = 6'(STORE_LOG2);
      end
      win_lim_in  = {2'b00, base_ff} + (34'd1 << wlog);
      cap_lim_in  = {2'b00, base_ff} + (34'd1 << cap_log);
      end_in      = {2'b00, addr_ff} + 34'(size_ff);
      size_bad_in = (size_ff == 4'd0) || (size_ff > 4'(MAX_TRANSFER));
      moved_in    = '0;
      for (int i = 0; i < LANES; i++) begin
         lane_en_in[i] = strobe_ff[i] && (4'(i) < size_ff);
         moved_in      = moved_in + 4'(lane_en_in[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.check) begin
         end_ff      <= end_in;
         win_lim_ff  <= win_lim_in;
         cap_lim_ff  <= cap_lim_in;
         lane_en_ff  <= lane_en_in;
         moved_ff    <= moved_in;
         size_bad_ff <= size_bad_in;
      end
   end

   // Status in priority order: size, window, capacity.
   always_comb begin
      if (size_bad_ff) begin
         status_in = ST_SIZE_ERR;
      end else if ((addr_ff < base_ff) || (end_ff > win_lim_ff)) begin
         status_in = ST_DECODE_ERR;
      end else if (end_ff > cap_lim_ff) begin
         status_in = ST_CAP_ERR;
      end else begin
         status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         status_ff <= status_in;
         offset_ff <= addr_ff[STORE_LOG2-1:0] - base_ff[STORE_LOG2-1:0];
      end
   end

   // Bank b holds the bytes whose store offset is b modulo the lane count.
   // Lane i of the item lands in bank (offset + i) mod 8; banks below the
   // starting bank take the next row.
   for (genvar b = 0; b < LANES; b++) begin : g_bank
      localparam logic [LANE_LOG2-1:0] BANK = LANE_LOG2'(b);
      logic [LANE_LOG2-1:0] lane;
      logic [ROW_BITS-1:0]  row;

      assign lane = BANK - offset_ff[LANE_LOG2-1:0];
      assign row  = offset_ff[STORE_LOG2-1:LANE_LOG2]
                  + ROW_BITS'(BANK < offset_ff[LANE_LOG2-1:0]);

      assign bank_addr[b]  = cmd.clear ? clear_row_ff : row;
      assign bank_we[b]    = cmd.clear || (cmd.access && ok && writing && lane_en_ff[lane]);
      assign bank_wdata[b] = cmd.clear ? 8'h00 : wdata_ff[8*lane +: 8];

      wssc_bank u_bank (
         .clock    (clock),
         .we       (bank_we[b]),
         .re       (cmd.access),
         .addr     (bank_addr[b]),
         .wdata    (bank_wdata[b]),
         .rdata_ff (bank_rdata[b])
      );
   end

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         rdata[8*i +: 8] = (ok && !writing && lane_en_ff[i])
                         ? bank_rdata[offset_ff[LANE_LOG2-1:0] + LANE_LOG2'(i)] : 8'h00;
      end
   end

   // Counters move while the memory access runs.
   always_ff @(posedge clock) begin
      if (reset) begin
         read_cnt_ff   <= '0;
         write_cnt_ff  <= '0;
         rbytes_cnt_ff <= '0;
         wbytes_cnt_ff <= '0;
         err_cnt_ff    <= '0;
         dbg_cnt_ff    <= '0;
      end else if (cmd.access) begin
         if (!ok) begin
            if (counted) begin
               err_cnt_ff <= sat_add(err_cnt_ff, 4'd1);
            end
         end else if (counted) begin
            if (writing) begin
               write_cnt_ff  <= sat_add(write_cnt_ff, 4'd1);
               wbytes_cnt_ff <= sat_add(wbytes_cnt_ff, moved_ff);
            end else begin
               read_cnt_ff   <= sat_add(read_cnt_ff, 4'd1);
               rbytes_cnt_ff <= sat_add(rbytes_cnt_ff, moved_ff);
            end
         end else if (writing) begin
            dbg_cnt_ff <= sat_add(dbg_cnt_ff, moved_ff);
         end
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= {dbg_cnt_ff, err_cnt_ff, wbytes_cnt_ff, rbytes_cnt_ff,
                           write_cnt_ff, read_cnt_ff, rdata};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wssc_ctrl.sv =====
// Controller: sequences the store clear after reset and the steps of one item.
// Depends on wssc_pkg; drives the command struct of wssc_datapath.
`default_nettype none

module wssc_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire wssc_pkg::stat_type stat,
   output wssc_pkg::cmd_type       cmd
);
   import wssc_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_ACCESS;
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            // Waits only while the previous result still sits unclaimed.
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/wssc_checker.sv =====
// Port-level checker for the windowed SRAM core, bound to the top level.
// Depends on wssc_pkg for widths and status codes.
`default_nettype none

module wssc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_tvalid,
   input wire logic                             req_tready,
   input wire logic                             rsp_tvalid,
   input wire logic                             rsp_tready,
   input wire logic [wssc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [1:0]                       rsp_tuser
);
   import wssc_pkg::*;

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped before it was taken");

   // One item at a time: no second item right after an accepted one.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted back to back");

   // Failed accesses return no read bytes.
   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_OK) |-> (rsp_tdata[63:0] == 64'd0))
      else $error("read data on a failed access");

   // Reset leaves no result offered and starts the store clear.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("block active right after reset");

endmodule

bind windowed_sram_with_strobes_and_counters_core wssc_checker u_wssc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
